@@ rtl/imh_pkg.sv @@
// shared types, constants and control store for the indexed min-heap insert block
// no dependencies
package imh_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_W         = 4;
    localparam int PRIO_W       = 32;
    localparam int STEP_W       = 3;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]          item_id;
        logic signed [PRIO_W-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic [3:0]               final_slot;
        logic [4:0]               entry_count;
        logic [ID_W-1:0]          top_id;
        logic signed [PRIO_W-1:0] top_priority;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_CHECK,
        OP_SIFT,
        OP_PLACE,
        OP_DONE
    } t_op;

    typedef enum logic [2:0] {
        C_ACCEPT,
        C_REJECT,
        C_SWAP_UP,
        C_ALWAYS,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [STEP_W-1:0] tgt_t;
        logic [STEP_W-1:0] tgt_f;
    } t_uword;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic accept;
        logic reject;
        logic swap_up;
        logic out_free;
    } t_flags;

    localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SIFT  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_PLACE = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DONE  = 3'd4;

    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_FETCH: w = '{OP_FETCH, C_ACCEPT,   STEP_CHECK, STEP_FETCH};
            STEP_CHECK: w = '{OP_CHECK, C_REJECT,   STEP_DONE,  STEP_SIFT};
            STEP_SIFT:  w = '{OP_SIFT,  C_SWAP_UP,  STEP_SIFT,  STEP_PLACE};
            STEP_PLACE: w = '{OP_PLACE, C_ALWAYS,   STEP_DONE,  STEP_DONE};
            STEP_DONE:  w = '{OP_DONE,  C_OUT_FREE, STEP_FETCH, STEP_DONE};
            default:    w = '{OP_FETCH, C_ALWAYS,   STEP_FETCH, STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/imh_ucode.sv @@
// microcode sequencer: step counter, control store lookup and conditional jumps
// depends on imh_pkg
module imh_ucode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  imh_pkg::t_flags i_flags,
    output imh_pkg::t_ctrl  o_ctrl
);
    import imh_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w;
    logic              cond_true;

    assign w = ucode_rom(r_step);

    always_comb begin
        case (w.cond)
            C_ACCEPT:   cond_true = i_flags.accept;
            C_REJECT:   cond_true = i_flags.reject;
            C_SWAP_UP:  cond_true = i_flags.swap_up;
            C_ALWAYS:   cond_true = 1'b1;
            C_OUT_FREE: cond_true = i_flags.out_free;
            default:    cond_true = 1'b1;
        endcase
    end

    always_comb begin
        n_step = cond_true ? w.tgt_t : w.tgt_f;
    end

    always_comb begin
        o_ctrl.op = w.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

@@ rtl/imh_datapath.sv @@
// heap datapath: slot memory, id map, presence flags, count, top copy and result register
// depends on imh_pkg; driven by imh_ucode
module imh_datapath #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  imh_pkg::t_ctrl     i_ctrl,
    output imh_pkg::t_flags    o_flags,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  imh_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output imh_pkg::t_out_item o_out_item
);
    import imh_pkg::*;

    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_DEPTH = (CAPACITY < 16) ? CAPACITY : 16;
    localparam int IDX_W    = $clog2(ID_DEPTH);

    t_entry             mem_heap [CAPACITY];
    logic [SLOT_W-1:0]  mem_pos  [ID_DEPTH];

    logic [ID_W-1:0]          r_id;
    logic signed [PRIO_W-1:0] r_prio;
    logic [SLOT_W-1:0]        r_slot;
    logic [SLOT_W-1:0]        n_slot;
    logic [CNT_W-1:0]         r_count;
    logic [ID_DEPTH-1:0]      r_present;
    t_status                  r_status;
    t_entry                   r_top;
    t_entry                   r_rdata;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic              accept;
    logic              id_ok;
    logic              full;
    logic              reject;
    t_status           chk_status;
    logic              swap;
    logic [SLOT_W-1:0] slot_parent;
    logic [SLOT_W-1:0] rd_addr;
    logic              out_free;
    logic              heap_we;
    t_entry            heap_wd;
    logic              pos_we;
    logic [IDX_W-1:0]  pos_wa;

    assign o_in_ready = (i_ctrl.op == OP_FETCH);
    assign accept     = i_in_valid && o_in_ready;
    assign id_ok      = ({{(32-ID_W){1'b0}}, r_id} < 32'(CAPACITY));
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign out_free   = !r_out_valid || i_out_ready;
    assign slot_parent = (r_slot - SLOT_W'(1)) >> 1;
    assign swap       = (r_slot != '0) && (r_prio <= r_rdata.prio);

    always_comb begin
        reject     = 1'b0;
        chk_status = ST_ACCEPTED;
        if (!id_ok || full) begin
            reject     = 1'b1;
            chk_status = ST_FULL;
        end else if (r_present[r_id[IDX_W-1:0]]) begin
            reject     = 1'b1;
            chk_status = ST_PRESENT;
        end
    end

    always_comb begin
        o_flags.accept   = accept;
        o_flags.reject   = reject;
        o_flags.swap_up  = swap && (slot_parent != '0);
        o_flags.out_free = out_free;
    end

    // next slot and parent read address
    always_comb begin
        n_slot = r_slot;
        case (i_ctrl.op)
            OP_CHECK: begin
                n_slot = reject ? '0 : r_count[SLOT_W-1:0];
            end
            OP_SIFT: begin
                if (swap) begin
                    n_slot = slot_parent;
                end
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    assign rd_addr = (n_slot - SLOT_W'(1)) >> 1;

    always_comb begin
        heap_we = 1'b0;
        heap_wd = r_rdata;
        pos_we  = 1'b0;
        pos_wa  = r_rdata.id[IDX_W-1:0];
        case (i_ctrl.op)
            OP_SIFT: begin
                heap_we = swap;
                pos_we  = swap;
            end
            OP_PLACE: begin
                heap_we = 1'b1;
                heap_wd = '{id: r_id, prio: r_prio};
                pos_we  = 1'b1;
                pos_wa  = r_id[IDX_W-1:0];
            end
            default: begin
                heap_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            mem_heap[r_slot] <= heap_wd;
        end
        r_rdata <= mem_heap[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            mem_pos[pos_wa] <= r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id   <= i_in_item.item_id;
            r_prio <= i_in_item.priority_req;
        end
        if (i_ctrl.op == OP_CHECK) begin
            r_status <= chk_status;
        end
        r_slot <= n_slot;
        if (i_ctrl.op == OP_PLACE && r_slot == '0) begin
            r_top <= '{id: r_id, prio: r_prio};
        end
        if (i_ctrl.op == OP_DONE && out_free) begin
            r_out.status      <= r_status;
            r_out.final_slot  <= 4'(r_slot);
            r_out.entry_count <= 5'(r_count);
            r_out.top_id      <= (r_count == '0) ? '0 : r_top.id;
            r_out.top_priority <= (r_count == '0) ? '0 : r_top.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.op == OP_CHECK && !reject) begin
                r_count                     <= r_count + CNT_W'(1);
                r_present[r_id[IDX_W-1:0]] <= 1'b1;
            end
            if (i_ctrl.op == OP_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_matches_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_present) == int'(r_count))
        else $error("presence flags disagree with entry count");

    a_reject_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_ACCEPTED |-> o_out_item.final_slot == '0)
        else $error("rejected item reports a non-zero slot");

    a_accept_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.op == OP_CHECK && !reject |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("accepted insert did not grow the heap");
`endif

endmodule

@@ rtl/indexed_min_heap_insert.sv @@
// indexed binary min-heap, insert side; built from imh_pkg, imh_ucode and imh_datapath
// steps: fetch, check, then a refused item goes straight to done; an inserted one passes
// through sift-up, place and done; the result is registered in done once the output is free
// one item at a time: a new item is taken only after the result of the last one is registered;
// sift-up climbs one level a cycle through the single registered read port of the slot memory
// reset: synchronous active low, empties the heap and clears the presence flags; no clearing pass
module indexed_min_heap_insert #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  imh_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output imh_pkg::t_out_item o_out_item
);
    import imh_pkg::*;

    t_ctrl  ctrl;
    t_flags flags;

    imh_ucode u_ucode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    imh_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_flags     (flags),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ tb/indexed_min_heap_insert_tb.sv @@
// self-checking testbench for indexed_min_heap_insert: directed table then random items,
// each result checked against a pinned table row or an in-bench model of the heap under random stalls
// depends on imh_pkg and indexed_min_heap_insert
`timescale 1ns / 100ps

module indexed_min_heap_insert_tb;
    import imh_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int N_PLAN       = 12;
    localparam int PER_PHASE    = 163;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        t_in_item  stim;
        logic      pinned;
        t_out_item want;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    // sideband travelling with the offered item
    logic      pin_on;
    t_out_item pin_want;

    int        recv_idle;
    int        hold_req;
    int        items_taken;
    int        results_seen;
    int        errors;
    int        quiet;
    t_out_item result_q [$];

    // heap model
    logic signed [31:0] heap_prio [CAP];
    logic [3:0]         heap_id   [CAP];
    logic [3:0]         id_slot   [CAP];
    logic [CAP-1:0]     id_held;
    int                 held_n;
    logic [CAP-1:0]     ids_used;

    t_row plan [N_PLAN] = '{
        '{'{4'd0,  32'sh7FFFFFFF}, 1'b1, '{ST_ACCEPTED, 4'd0, 5'd1, 4'd0, 32'sh7FFFFFFF}},
        '{'{4'd0,  32'sh00000005}, 1'b1, '{ST_PRESENT,  4'd0, 5'd1, 4'd0, 32'sh7FFFFFFF}},
        '{'{4'd1,  32'sh80000000}, 1'b1, '{ST_ACCEPTED, 4'd0, 5'd2, 4'd1, 32'sh80000000}},
        '{'{4'd2,  32'sh80000000}, 1'b1, '{ST_ACCEPTED, 4'd0, 5'd3, 4'd2, 32'sh80000000}},
        '{'{4'd15, 32'shFFFFFFFF}, 1'b0, '0},
        '{'{4'd10, 32'sh00010000}, 1'b0, '0},
        '{'{4'd5,  32'sh00010000}, 1'b0, '0},
        '{'{4'd1,  32'sh12345678}, 1'b1, '{ST_PRESENT,  4'd0, 5'd6, 4'd2, 32'sh80000000}},
        '{'{4'd3,  32'sh80000000}, 1'b0, '0},
        '{'{4'd12, 32'sh7FFFFFFF}, 1'b0, '0},
        '{'{4'd8,  32'shAAAAAAAA}, 1'b0, '0},
        '{'{4'd7,  32'sh55555555}, 1'b0, '0}
    };

    indexed_min_heap_insert dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out_item heap_insert(input t_in_item it);
        t_out_item          r;
        int                 slot;
        int                 up;
        logic               climbing;
        logic signed [31:0] tp;
        logic [3:0]         tid;
        r = '0;
        slot = 0;
        if (held_n >= CAP) begin
            r.status = ST_FULL;
        end else if (id_held[it.item_id]) begin
            r.status = ST_PRESENT;
        end else begin
            r.status = ST_ACCEPTED;
            slot = held_n;
            heap_prio[slot] = it.priority_req;
            heap_id[slot] = it.item_id;
            id_slot[it.item_id] = slot[3:0];
            id_held[it.item_id] = 1'b1;
            held_n++;
            climbing = 1'b1;
            // ties rise past older entries
            while (slot > 0 && climbing) begin
                up = (slot - 1) / 2;
                if (heap_prio[slot] <= heap_prio[up]) begin
                    tp = heap_prio[up];
                    tid = heap_id[up];
                    heap_prio[up] = heap_prio[slot];
                    heap_id[up] = heap_id[slot];
                    heap_prio[slot] = tp;
                    heap_id[slot] = tid;
                    id_slot[heap_id[up]] = up[3:0];
                    id_slot[heap_id[slot]] = slot[3:0];
                    slot = up;
                end else begin
                    climbing = 1'b0;
                end
            end
        end
        r.final_slot = slot[3:0];
        r.entry_count = held_n[4:0];
        if (held_n > 0) begin
            r.top_id = heap_id[0];
            r.top_priority = heap_prio[0];
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (errors < PRINT_LIMIT)
            $display("%0t: %s mismatch on result %0d: got %h, want %h",
                     $time, field, results_seen, got, want);
        errors++;
    endtask

    task automatic compare_result(input t_out_item got, input t_out_item want);
        if (got.status !== want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.final_slot !== want.final_slot)
            flag_mismatch("final_slot", 32'(got.final_slot), 32'(want.final_slot));
        if (got.entry_count !== want.entry_count)
            flag_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        if (got.top_id !== want.top_id)
            flag_mismatch("top_id", 32'(got.top_id), 32'(want.top_id));
        if (got.top_priority !== want.top_priority)
            flag_mismatch("top_priority", got.top_priority, want.top_priority);
    endtask

    // mostly re-offers held ids so the heap fills slowly
    function automatic t_in_item next_item();
        t_in_item it;
        int       pick;
        logic [3:0] id;
        pick = $urandom_range(11);
        id = 4'($urandom_range(CAP - 1));
        if (pick == 0 && ids_used != '1) begin
            while (ids_used[id]) id = 4'($urandom_range(CAP - 1));
        end else if (pick != 1 && ids_used != '0) begin
            while (!ids_used[id]) id = 4'($urandom_range(CAP - 1));
        end
        ids_used[id] = 1'b1;
        it.item_id = id;
        case ($urandom_range(7))
            0:       it.priority_req = 32'sh7FFFFFFF;
            1:       it.priority_req = 32'sh80000000;
            2:       it.priority_req = '0;
            3, 4:    it.priority_req = ($urandom_range(4) - 2) << 16;
            default: it.priority_req = $urandom;
        endcase
        return it;
    endfunction

    task automatic offer(input t_in_item it, input logic pinned, input t_out_item want,
                         input int send_idle);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        pin_on     <= pinned;
        pin_want   <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        do @(posedge i_clk); while (results_seen != items_taken);
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    flag_mismatch("unexpected result", 32'(o_out_item.status), '0);
                end else begin
                    want = result_q.pop_front();
                    compare_result(o_out_item, want);
                end
                results_seen <= results_seen + 1;
            end
            if (i_in_valid && o_in_ready) begin
                want = heap_insert(i_in_item);
                result_q.push_back(pin_on ? pin_want : want);
                items_taken <= items_taken + 1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("indexed_min_heap_insert_tb: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        pin_on       = 1'b0;
        pin_want     = '0;
        recv_idle    = 0;
        hold_req     = 0;
        items_taken  = 0;
        results_seen = 0;
        errors       = 0;
        quiet        = 0;
        id_held      = '0;
        held_n       = 0;
        ids_used     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        recv_idle <= 63;

        foreach (plan[k]) begin
            ids_used[plan[k].stim.item_id] = 1'b1;
            offer(plan[k].stim, plan[k].pinned, plan[k].want, 37);
        end
        i_in_valid <= 1'b0;
        drain();

        // long output stall while items keep coming
        hold_req <= hold_req + 1;
        for (int n = 0; n < PER_PHASE; n++) offer(next_item(), 1'b0, '0, 37);
        recv_idle <= 37;
        for (int n = 0; n < PER_PHASE; n++) offer(next_item(), 1'b0, '0, 63);
        recv_idle <= 0;
        for (int n = 0; n < PER_PHASE; n++) offer(next_item(), 1'b0, '0, 0);
        i_in_valid <= 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0 && result_q.size() == 0) begin
            $display("indexed_min_heap_insert_tb: PASS");
        end else begin
            $display("indexed_min_heap_insert_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/imh_pkg.sv
rtl/imh_ucode.sv
rtl/imh_datapath.sv
rtl/indexed_min_heap_insert.sv
tb/indexed_min_heap_insert_tb.sv
